FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define SXH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Next-cycle implication, disabled while in reset.
`define SXH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

FILE: rtl/sxh_pkg.sv
// Shared types and constants of the simplified xxHash64 stream hash.
// No dependencies.
package sxh_pkg;

	localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] PRIME3 = 64'h27D4EB2F165667C5;
	localparam logic [63:0] PRIME4 = 64'h165667B19D37E5E3;
	localparam logic [63:0] SEED   = 64'h165667B19D37E5E3;

	localparam int LENGTH_BITS_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [1:0] {
		KIND_FULL,
		KIND_FULL_LAST,
		KIND_TAIL,
		KIND_EMPTY
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  nb;
		logic [63:0] data;
	} q_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MIX_A,
		ST_MIX_WAIT_A,
		ST_MIX_B,
		ST_MIX_WAIT_B,
		ST_UPDATE,
		ST_AVAL_A,
		ST_AVAL_WAIT_A,
		ST_AVAL_B,
		ST_AVAL_WAIT_B,
		ST_EMIT
	} state_t;

endpackage

FILE: rtl/simplified_xxh64_stream_hash_top.sv
// Top level of the simplified xxHash64 stream hash: front, queue, sequencer.
// Depends on sxh_pkg, sxh_front, sxh_fifo, sxh_back and assert_macros.svh.
//
//   channel   handshake             payload
//   input     in_valid / in_ready   data_word[63:0], valid_bytes[3:0], last
//   output    out_valid / out_ready hash[63:0]
//
// A full word not ending the message runs the sequencer's mix and chain update,
// a word that ends it also the avalanche, an empty final item the avalanche only;
// the shared two-stage 64-bit multiplier runs twice per word and twice per avalanche.
// Reset clears the queue, the sequencer and the result valid flag; the chain
// starts at the seed and the byte count at zero.
// The front keeps taking transfers while the queue has room; a stalled result
// freezes the sequencer with the next hash finished until the slot frees.
`include "assert_macros.svh"

module simplified_xxh64_stream_hash_top #(
	parameter int LENGTH_BITS = sxh_pkg::LENGTH_BITS_DEF,
	parameter int QUEUE_DEPTH = sxh_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] data_word,
	input  logic [3:0]  valid_bytes,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] hash
);

	sxh_pkg::q_entry_t wr_entry, rd_entry;
	logic              push, pop, q_full, q_empty;

	sxh_front u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_word   (data_word),
		.valid_bytes (valid_bytes),
		.last        (last),
		.q_full      (q_full),
		.push        (push),
		.entry       (wr_entry)
	);

	sxh_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.full     (q_full),
		.empty    (q_empty)
	);

	sxh_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_entry  (rd_entry),
		.q_empty   (q_empty),
		.q_pop     (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hash      (hash)
	);

	`SXH_ASSERT_NEXT(a_push_fills_queue, clk, arst_n, push, !q_empty)
	`SXH_ASSERT_NOW(a_pop_needs_entry, clk, arst_n, pop, !q_empty)
	`SXH_ASSERT_NOW(a_full_blocks_input, clk, arst_n, q_full, !push)

endmodule

FILE: rtl/sxh_mul.sv
// Two-stage 64x64 multiplier, low 64 bits of the product, from 32x32 pieces.
// No dependencies.
module sxh_mul (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	logic [63:0] ll;
	logic [31:0] hl, lh;
	logic [63:0] p0_s1;
	logic [31:0] p1_s1, p2_s1;
	logic [63:0] p_s2;

	assign ll = a[31:0] * b[31:0];
	assign hl = a[63:32] * b[31:0];
	assign lh = a[31:0] * b[63:32];

	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1 <= ll;
			p1_s1 <= hl;
			p2_s1 <= lh;
			p_s2  <= p0_s1 + {p1_s1 + p2_s1, 32'b0};
		end
	end

	assign p = p_s2;

endmodule

FILE: rtl/sxh_front.sv
// Input side: takes transfers, clamps the byte count, masks short words, classifies.
// Depends on sxh_pkg.
module sxh_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [63:0]       data_word,
	input  logic [3:0]        valid_bytes,
	input  logic              last,
	input  logic              q_full,
	output logic              push,
	output sxh_pkg::q_entry_t entry
);

	logic [3:0]  nb;
	logic [63:0] tail;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;
	assign nb       = valid_bytes[3] ? 4'd8 : valid_bytes;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			tail[i*8 +: 8] = (4'(i) < nb) ? data_word[i*8 +: 8] : 8'h00;
		end
	end

	always_comb begin
		entry.nb = nb;
		if (nb == 4'd8) begin
			entry.kind = last ? sxh_pkg::KIND_FULL_LAST : sxh_pkg::KIND_FULL;
			entry.data = data_word;
		end else begin
			entry.kind = (tail == 64'd0) ? sxh_pkg::KIND_EMPTY : sxh_pkg::KIND_TAIL;
			entry.data = tail;
		end
	end

endmodule

FILE: rtl/sxh_fifo.sv
// Small queue of classified words between the front and the hash sequencer.
// Depends on sxh_pkg.
module sxh_fifo #(
	parameter int DEPTH = sxh_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sxh_pkg::q_entry_t wr_entry,
	input  logic              pop,
	output sxh_pkg::q_entry_t rd_entry,
	output logic              full,
	output logic              empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	sxh_pkg::q_entry_t entries_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign rd_entry = entries_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/sxh_back.sv
// Hash sequencer: word scramble, chain update, length fold, avalanche, result register.
// Depends on sxh_pkg and sxh_mul.
module sxh_back #(
	parameter int LENGTH_BITS = sxh_pkg::LENGTH_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sxh_pkg::q_entry_t rd_entry,
	input  logic              q_empty,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [63:0]       hash
);

	sxh_pkg::state_t        state_q, state_d;
	sxh_pkg::kind_t         kind_q;
	logic [63:0]            data_q;
	logic [63:0]            h_q;
	logic [LENGTH_BITS-1:0] bc_q;
	logic [63:0]            hash_q;
	logic                   out_valid_q;

	logic        mul_en;
	logic [63:0] mul_a, mul_b, mul_p;
	logic        is_full, out_free, emit;
	logic [63:0] x, t, mix_h;

	function automatic logic [63:0] rotl31(input logic [63:0] v);
		return {v[32:0], v[63:33]};
	endfunction

	function automatic logic [63:0] rotl27(input logic [63:0] v);
		return {v[36:0], v[63:37]};
	endfunction

	sxh_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	assign is_full  = (kind_q == sxh_pkg::KIND_FULL) || (kind_q == sxh_pkg::KIND_FULL_LAST);
	assign out_free = !out_valid_q || out_ready;
	assign x        = h_q ^ 64'(bc_q);
	assign t        = rotl27(h_q ^ mul_p);
	assign mix_h    = (t << 2) + t + sxh_pkg::SEED;

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		emit    = 1'b0;
		mul_en  = 1'b1;
		mul_a   = data_q;
		mul_b   = sxh_pkg::PRIME2;
		unique case (state_q)
			sxh_pkg::ST_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = (rd_entry.kind == sxh_pkg::KIND_EMPTY) ?
						sxh_pkg::ST_AVAL_A : sxh_pkg::ST_MIX_A;
				end
			end
			sxh_pkg::ST_MIX_A: begin
				mul_b   = is_full ? sxh_pkg::PRIME2 : sxh_pkg::PRIME3;
				state_d = sxh_pkg::ST_MIX_WAIT_A;
			end
			sxh_pkg::ST_MIX_WAIT_A: state_d = sxh_pkg::ST_MIX_B;
			sxh_pkg::ST_MIX_B: begin
				mul_a   = rotl31(mul_p);
				mul_b   = is_full ? sxh_pkg::PRIME1 : sxh_pkg::PRIME4;
				state_d = sxh_pkg::ST_MIX_WAIT_B;
			end
			sxh_pkg::ST_MIX_WAIT_B: state_d = sxh_pkg::ST_UPDATE;
			sxh_pkg::ST_UPDATE: begin
				state_d = (kind_q == sxh_pkg::KIND_FULL) ?
					sxh_pkg::ST_IDLE : sxh_pkg::ST_AVAL_A;
			end
			sxh_pkg::ST_AVAL_A: begin
				mul_a   = x ^ (x >> 33);
				mul_b   = sxh_pkg::PRIME2;
				state_d = sxh_pkg::ST_AVAL_WAIT_A;
			end
			sxh_pkg::ST_AVAL_WAIT_A: state_d = sxh_pkg::ST_AVAL_B;
			sxh_pkg::ST_AVAL_B: begin
				mul_a   = mul_p ^ (mul_p >> 29);
				mul_b   = sxh_pkg::PRIME3;
				state_d = sxh_pkg::ST_AVAL_WAIT_B;
			end
			sxh_pkg::ST_AVAL_WAIT_B: state_d = sxh_pkg::ST_EMIT;
			sxh_pkg::ST_EMIT: begin
				// hold the product while the result register is occupied
				if (out_free) begin
					emit    = 1'b1;
					state_d = sxh_pkg::ST_IDLE;
				end else begin
					mul_en = 1'b0;
				end
			end
			default: state_d = sxh_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sxh_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			h_q         <= sxh_pkg::SEED;
			bc_q        <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit) begin
				h_q  <= sxh_pkg::SEED;
				bc_q <= '0;
			end else begin
				if (q_pop) begin
					bc_q <= bc_q + LENGTH_BITS'(rd_entry.nb);
				end
				if (state_q == sxh_pkg::ST_UPDATE) begin
					h_q <= is_full ? mix_h : (h_q ^ mul_p);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			kind_q <= rd_entry.kind;
			data_q <= rd_entry.data;
		end
		if (emit) begin
			hash_q <= mul_p ^ (mul_p >> 32);
		end
	end

	assign out_valid = out_valid_q;
	assign hash      = hash_q;

endmodule

FILE: test/simplified_xxh64_stream_hash_top_tb.sv
// Testbench for simplified_xxh64_stream_hash_top: directed and random messages, each hash
// checked against a local model of the chain and avalanche mix. Depends on sxh_pkg and the RTL.
module simplified_xxh64_stream_hash_top_tb;

	localparam int LEN_BITS    = sxh_pkg::LENGTH_BITS_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 30;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] data_word = '0;
	logic [3:0]  valid_bytes = '0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] hash;

	logic [63:0]         chain_acc = sxh_pkg::SEED;
	logic [LEN_BITS-1:0] msg_len = '0;
	logic [63:0]         pending_hashes[$];

	int in_idle_pct = 0;
	int out_idle_pct = 0;
	int items_sent = 0;
	int messages_sent = 0;
	int hashes_checked = 0;
	int errors = 0;
	int stall_cycles = 0;

	simplified_xxh64_stream_hash_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_word  (data_word),
		.valid_bytes(valid_bytes),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hash       (hash)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] rotl(input logic [63:0] v, input int r);
		return (v << r) | (v >> (64 - r));
	endfunction

	// Folds one word into the running chain; returns 1 when the message completes.
	function automatic bit fold_word(input logic [63:0] w, input logic [3:0] nb_raw,
			input logic fin, output logic [63:0] digest);
		int          nb;
		logic [63:0] h;
		logic [63:0] k;
		logic [63:0] prod;
		nb = (nb_raw > 8) ? 8 : nb_raw;
		msg_len = msg_len + LEN_BITS'(nb);
		h = chain_acc;
		digest = '0;
		if (nb == 8) begin
			prod = w * sxh_pkg::PRIME2;
			k = rotl(prod, 31);
			k = k * sxh_pkg::PRIME1;
			h = rotl(h ^ k, 27);
			h = h * 64'd5 + sxh_pkg::SEED;
			if (!fin) begin
				chain_acc = h;
				return 1'b0;
			end
		end else begin
			k = w & ((64'd1 << (nb * 8)) - 64'd1);
			if (k != 0) begin
				prod = k * sxh_pkg::PRIME3;
				k = rotl(prod, 31);
				k = k * sxh_pkg::PRIME4;
				h = h ^ k;
			end
		end
		h = h ^ 64'(msg_len);
		h = h ^ (h >> 33);
		h = h * sxh_pkg::PRIME2;
		h = h ^ (h >> 29);
		h = h * sxh_pkg::PRIME3;
		h = h ^ (h >> 32);
		digest = h;
		chain_acc = sxh_pkg::SEED;
		msg_len = '0;
		return 1'b1;
	endfunction

	function automatic logic [63:0] pick_word();
		case ($urandom_range(9))
			0: return 64'd0;
			1: return '1;
			2: return 64'd1 << $urandom_range(63);
			3: return ~(64'd1 << $urandom_range(63));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_word(input logic [63:0] w, input logic [3:0] nb, input logic fin);
		logic [63:0] digest;
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
		end
		in_valid <= 1'b1;
		data_word <= w;
		valid_bytes <= nb;
		last <= fin;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (fold_word(w, nb, fin, digest)) begin
			pending_hashes.push_back(digest);
			messages_sent++;
		end
	endtask

	// out_ready follows the current stall rate
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_idle_pct);
	end

	// result check and no-progress watchdog
	always @(posedge clk) begin
		logic [63:0] exp_hash;
		if (arst_n && out_valid && out_ready) begin
			if (pending_hashes.size() == 0) begin
				$error("hash: unexpected transfer, actual %h", hash);
				errors++;
			end else begin
				exp_hash = pending_hashes.pop_front();
				hashes_checked++;
				if (hash !== exp_hash) begin
					$error("hash: expected %h, actual %h", exp_hash, hash);
					errors++;
				end
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("simplified_xxh64_stream_hash_top: mismatch");
			$finish;
		end
	end

	task automatic test_full_words();
		send_word(64'd0, 4'd8, 1'b1);
		send_word('1, 4'd8, 1'b1);
		send_word('1, 4'd8, 1'b0);
		send_word(64'h0123456789ABCDEF, 4'd8, 1'b0);
		send_word(64'h8000000000000001, 4'd8, 1'b1);
	endtask

	task automatic test_short_tails();
		int n;
		send_word('1, 4'd8, 1'b0);
		send_word('1, 4'd1, 1'b1);
		// short word without last still ends the message
		send_word(64'hFF00_0000_0000_0000 | {$urandom, $urandom}, 4'd7, 1'b0);
		// nonzero bytes only above the valid ones: tail masks to zero
		send_word(64'hFFFF_FFFF_0000_0000, 4'd4, 1'b1);
		for (n = 2; n <= 6; n++)
			send_word(pick_word(), 4'(n), 1'b1);
	endtask

	task automatic test_empty_items();
		send_word('1, 4'd0, 1'b1);
		send_word('1, 4'd0, 1'b0);
		send_word(pick_word(), 4'd8, 1'b0);
		send_word(pick_word(), 4'd8, 1'b0);
		send_word(64'hDEAD_BEEF_DEAD_BEEF, 4'd0, 1'b1);
	endtask

	task automatic test_oversized_counts();
		send_word(pick_word(), 4'd9, 1'b0);
		send_word(pick_word(), 4'd15, 1'b1);
		send_word('1, 4'd12, 1'b1);
	endtask

	task automatic test_random_messages(input int count);
		int stop_at;
		int nfull;
		int i;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 15) begin
				send_word(pick_word(), 4'($urandom_range(15)), 1'($urandom_range(1)));
			end else begin
				nfull = ($urandom_range(9) < 7) ? $urandom_range(3) : $urandom_range(12);
				for (i = 0; i < nfull; i++)
					send_word(pick_word(),
						($urandom_range(19) == 0) ? 4'($urandom_range(15, 9)) : 4'd8, 1'b0);
				case ($urandom_range(3))
					0: send_word(pick_word(), 4'd8, 1'b1);
					1: send_word(pick_word(), 4'($urandom_range(7, 1)), 1'b1);
					2: send_word(pick_word(), 4'($urandom_range(7, 1)), 1'($urandom_range(1)));
					default: send_word(pick_word(), 4'd0, 1'b1);
				endcase
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_idle_pct = 25;
		out_idle_pct = 49;
		test_full_words();
		test_short_tails();
		test_empty_items();
		test_oversized_counts();
		test_random_messages(600);

		in_idle_pct = 49;
		out_idle_pct = 25;
		test_random_messages(600);

		in_idle_pct = 0;
		out_idle_pct = 0;
		test_random_messages(600);

		in_valid <= 1'b0;
		while (pending_hashes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words forming %0d messages; checked %0d hashes.",
			items_sent, messages_sent, hashes_checked);
		$display("Covered full, short, empty and oversized words under three stall mixes.");
		if (errors == 0)
			$display("simplified_xxh64_stream_hash_top: match");
		else
			$display("simplified_xxh64_stream_hash_top: mismatch");
		$finish;
	end

endmodule
